### rtl/rbnh_pkg.sv
package rbnh_pkg;

    localparam int MAX_BOXES = 256;
    localparam int FRAC_BITS = 16;
    localparam int VAL_W     = 32;
    localparam int DIST_W    = 31;
    localparam int IDX_W     = 8;
    localparam int CNT_W     = $clog2(MAX_BOXES);
    localparam int AXES      = 3;
    localparam int AXIS_W    = 2;
    localparam int DIFF_W    = VAL_W + 1;
    localparam int PROD_W    = DIFF_W + VAL_W;
    localparam int NUM_W     = 2 * FRAC_BITS + 1;
    localparam int DCNT_W    = $clog2(NUM_W + 1);

    localparam logic ACT_RAY = 1'b0;
    localparam logic ACT_BOX = 1'b1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_RECIP_START,
        ST_RECIP_WAIT,
        ST_BOX,
        ST_FINAL
    } t_state;

    typedef struct packed {
        logic                    start;
        logic signed [VAL_W-1:0] divisor;
    } t_div_req;

    typedef struct packed {
        logic                    done;
        logic signed [VAL_W-1:0] quotient;
    } t_div_rsp;

endpackage

### rtl/rbnh_recip.sv
module rbnh_recip (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  rbnh_pkg::t_div_req i_req,
    output rbnh_pkg::t_div_rsp o_rsp
);
    import rbnh_pkg::*;

    logic [VAL_W-1:0]  r_rem;
    logic [NUM_W-1:0]  r_num;
    logic [NUM_W-1:0]  r_quo;
    logic [VAL_W-1:0]  r_div;
    logic              r_neg;
    logic [DCNT_W-1:0] r_cnt;
    logic              r_busy;
    logic              r_done;
    logic signed [VAL_W-1:0] r_q;

    logic [VAL_W:0]   trial;
    logic             ge;
    logic [VAL_W-1:0] mag;
    logic [NUM_W-1:0] q_fin;
    logic signed [VAL_W-1:0] q_sat;

    always_comb begin
        trial = {r_rem, r_num[NUM_W-1]};
        ge    = trial >= {1'b0, r_div};
        mag   = i_req.divisor[VAL_W-1] ? VAL_W'(-i_req.divisor) : i_req.divisor;
        q_fin = {r_quo[NUM_W-2:0], ge};
        if (!r_neg) begin
            if (q_fin > NUM_W'({1'b0, {(VAL_W-1){1'b1}}})) q_sat = {1'b0, {(VAL_W-1){1'b1}}};
            else q_sat = q_fin[VAL_W-1:0];
        end else begin
            if (q_fin > NUM_W'({1'b1, {(VAL_W-1){1'b0}}})) q_sat = {1'b1, {(VAL_W-1){1'b0}}};
            else q_sat = VAL_W'(-q_fin[VAL_W-1:0]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == DCNT_W'(NUM_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_rem <= '0;
            r_num <= {1'b1, {(NUM_W-1){1'b0}}};
            r_quo <= '0;
            r_div <= mag;
            r_neg <= i_req.divisor[VAL_W-1];
        end else if (r_busy) begin
            r_rem <= ge ? VAL_W'(trial - {1'b0, r_div}) : trial[VAL_W-1:0];
            r_num <= {r_num[NUM_W-2:0], 1'b0};
            r_quo <= q_fin;
            if (r_cnt == DCNT_W'(NUM_W - 1)) r_q <= q_sat;
        end
    end

    assign o_rsp.done     = r_done;
    assign o_rsp.quotient = r_q;

endmodule

### rtl/rbnh_mul.sv
module rbnh_mul (
    input  logic                                 i_clk,
    input  logic signed [rbnh_pkg::DIFF_W-1:0]   i_a,
    input  logic signed [rbnh_pkg::VAL_W-1:0]    i_b,
    output logic signed [rbnh_pkg::PROD_W-1:0]   o_p
);
    import rbnh_pkg::*;

    always_ff @(posedge i_clk) begin
        o_p <= PROD_W'(i_a) * PROD_W'(i_b);
    end

endmodule

### rtl/ray_box_nearest_hit.sv
// Nearest-hit search of one ray against a stream of axis-aligned boxes (slab test, Q16.16).
// A ray item holds the input stalled after it is taken: the three reciprocals of the direction
// run one after another through a shared bit-serial divider, each axis in turn (start, 33
// divide steps, write back). A box item holds the input stalled while the six plane crossings
// issue one per cycle into a shared registered multiplier, after which the final state
// updates the best distance. One item is in work at a time. The result sits in an output
// register, so a box that does not end a ray proceeds while it waits; a box that ends a ray
// waits in its final state until the output register is free.
module ray_box_nearest_hit
    import rbnh_pkg::*;
(
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_valid,
    output logic                              o_stall,
    input  logic                              i_action,
    input  logic signed [rbnh_pkg::VAL_W-1:0] i_first_x,
    input  logic signed [rbnh_pkg::VAL_W-1:0] i_first_y,
    input  logic signed [rbnh_pkg::VAL_W-1:0] i_first_z,
    input  logic signed [rbnh_pkg::VAL_W-1:0] i_second_x,
    input  logic signed [rbnh_pkg::VAL_W-1:0] i_second_y,
    input  logic signed [rbnh_pkg::VAL_W-1:0] i_second_z,
    input  logic [rbnh_pkg::DIST_W-1:0]       i_max_dist,
    input  logic                              i_last,
    output logic                              o_valid,
    input  logic                              i_stall,
    output logic                              o_hit,
    output logic [rbnh_pkg::DIST_W-1:0]       o_distance,
    output logic [rbnh_pkg::IDX_W-1:0]        o_box_index
);

    t_state r_state, n_state;

    logic signed [VAL_W-1:0] r_origin [AXES];
    logic signed [VAL_W-1:0] r_inv    [AXES];
    logic                    r_par    [AXES];
    logic signed [VAL_W-1:0] r_lo     [AXES];
    logic signed [VAL_W-1:0] r_hi     [AXES];
    logic signed [VAL_W-1:0] r_best;
    logic [IDX_W-1:0]        r_best_idx;
    logic                    r_found;
    logic [CNT_W-1:0]        r_count;
    logic [CNT_W-1:0]        r_this_idx;
    logic                    r_last;
    logic [AXIS_W-1:0]       r_axis;
    logic [2:0]              r_step;
    logic signed [DIFF_W-1:0] r_diff;
    logic signed [VAL_W-1:0] r_mop;
    logic signed [VAL_W-1:0] r_t0;
    logic signed [VAL_W-1:0] r_tmin;
    logic signed [VAL_W-1:0] r_tmax;
    logic                    r_hit;
    logic                    r_out_valid;
    logic                    r_out_hit;
    logic [DIST_W-1:0]       r_out_dist;
    logic [IDX_W-1:0]        r_out_idx;

    logic                    accept;
    t_div_req                div_req;
    t_div_rsp                div_rsp;
    logic signed [PROD_W-1:0] prod;
    logic [2:0]              upd;
    logic [AXIS_W-1:0]       upd_axis;
    logic [AXIS_W-1:0]       iss_axis;
    logic signed [PROD_W-FRAC_BITS-1:0] shifted;
    logic signed [VAL_W-1:0] t_cur;
    logic signed [VAL_W-1:0] t_near;
    logic signed [VAL_W-1:0] t_far;
    logic signed [VAL_W-1:0] nmin;
    logic signed [VAL_W-1:0] nmax;
    logic                    par_miss;
    logic                    out_free;
    logic                    out_load;
    logic signed [VAL_W-1:0] issue_bound;

    assign accept   = i_valid && !o_stall;
    assign o_stall  = (r_state != ST_IDLE);
    assign out_free = !r_out_valid || !i_stall;
    assign out_load = (r_state == ST_FINAL) && r_last && out_free;

    assign div_req.start   = (r_state == ST_RECIP_START);
    assign div_req.divisor = r_hi[r_axis];

    rbnh_recip u_recip (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .o_rsp   (div_rsp)
    );

    rbnh_mul u_mul (
        .i_clk (i_clk),
        .i_a   (r_diff),
        .i_b   (r_mop),
        .o_p   (prod)
    );

    always_comb begin
        iss_axis    = r_step[2:1];
        issue_bound = r_step[0] ? r_hi[iss_axis] : r_lo[iss_axis];
        upd         = r_step - 3'd2;
        upd_axis    = upd[2:1];
        shifted     = prod[PROD_W-1:FRAC_BITS];
        if (shifted > (PROD_W-FRAC_BITS)'(signed'({1'b0, {(VAL_W-1){1'b1}}})))
            t_cur = {1'b0, {(VAL_W-1){1'b1}}};
        else if (shifted < (PROD_W-FRAC_BITS)'(signed'({1'b1, {(VAL_W-1){1'b0}}})))
            t_cur = {1'b1, {(VAL_W-1){1'b0}}};
        else
            t_cur = shifted[VAL_W-1:0];
        t_near = (r_t0 > t_cur) ? t_cur : r_t0;
        t_far  = (r_t0 > t_cur) ? r_t0 : t_cur;
        nmin   = (t_near > r_tmin) ? t_near : r_tmin;
        nmax   = (t_far < r_tmax) ? t_far : r_tmax;
        par_miss = 1'b0;
        for (int a = 0; a < AXES; a++) begin
            if (r_par[a] && (r_origin[a] < r_lo[a] || r_origin[a] > r_hi[a])) par_miss = 1'b1;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (accept) n_state = (i_action == ACT_RAY) ? ST_RECIP_START : ST_BOX;
            end
            ST_RECIP_START: n_state = ST_RECIP_WAIT;
            ST_RECIP_WAIT: begin
                if (div_rsp.done) begin
                    n_state = (r_axis == AXIS_W'(AXES - 1)) ? ST_IDLE : ST_RECIP_START;
                end
            end
            ST_BOX: begin
                if (r_step == 3'd7) n_state = ST_FINAL;
            end
            ST_FINAL: begin
                if (!r_last || out_free) n_state = ST_IDLE;
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_state <= ST_IDLE;
        else r_state <= n_state;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int a = 0; a < AXES; a++) begin
                r_origin[a] <= '0;
                r_inv[a]    <= '0;
                r_par[a]    <= 1'b0;
            end
            r_best      <= '0;
            r_best_idx  <= '0;
            r_found     <= 1'b0;
            r_count     <= '0;
            r_out_valid <= 1'b0;
            r_axis      <= '0;
            r_step      <= '0;
        end else begin
            if (out_load) r_out_valid <= 1'b1;
            else if (r_out_valid && !i_stall) r_out_valid <= 1'b0;
            unique case (r_state)
                ST_IDLE: begin
                    if (accept) begin
                        r_lo[0] <= i_first_x;
                        r_lo[1] <= i_first_y;
                        r_lo[2] <= i_first_z;
                        r_hi[0] <= i_second_x;
                        r_hi[1] <= i_second_y;
                        r_hi[2] <= i_second_z;
                        r_last  <= i_last;
                        r_axis  <= '0;
                        r_step  <= '0;
                        if (i_action == ACT_RAY) begin
                            r_origin[0] <= i_first_x;
                            r_origin[1] <= i_first_y;
                            r_origin[2] <= i_first_z;
                            r_best      <= VAL_W'(i_max_dist);
                            r_best_idx  <= '0;
                            r_found     <= 1'b0;
                            r_count     <= '0;
                        end else begin
                            r_this_idx <= r_count;
                            r_count    <= r_count + 1'b1;
                            r_tmin     <= '0;
                            r_tmax     <= r_best;
                            r_hit      <= 1'b1;
                        end
                    end
                end
                ST_RECIP_START: ;
                ST_RECIP_WAIT: begin
                    if (div_rsp.done) begin
                        r_par[r_axis] <= (r_hi[r_axis] == '0);
                        r_inv[r_axis] <= (r_hi[r_axis] == '0) ? '0 : div_rsp.quotient;
                        r_axis        <= r_axis + 1'b1;
                    end
                end
                ST_BOX: begin
                    r_step <= r_step + 1'b1;
                    if (r_step < 3'd6) begin
                        r_diff <= DIFF_W'(issue_bound) - DIFF_W'(r_origin[iss_axis]);
                        r_mop  <= r_inv[iss_axis];
                    end
                    if (r_step == 3'd0 && par_miss) r_hit <= 1'b0;
                    if (r_step >= 3'd2 && !r_par[upd_axis]) begin
                        if (!upd[0]) begin
                            r_t0 <= t_cur;
                        end else begin
                            r_tmin <= nmin;
                            r_tmax <= nmax;
                            if (nmin > nmax) r_hit <= 1'b0;
                        end
                    end
                end
                ST_FINAL: begin
                    if (!r_last || out_free) begin
                        if (r_hit && r_tmin >= 0 && r_tmin < r_best) begin
                            r_best     <= r_tmin;
                            r_best_idx <= IDX_W'(r_this_idx);
                            r_found    <= 1'b1;
                        end
                        if (r_last) begin
                            if (r_hit && r_tmin >= 0 && r_tmin < r_best) begin
                                r_out_hit  <= 1'b1;
                                r_out_dist <= r_tmin[DIST_W-1:0];
                                r_out_idx  <= IDX_W'(r_this_idx);
                            end else begin
                                r_out_hit  <= r_found;
                                r_out_dist <= r_best[DIST_W-1:0];
                                r_out_idx  <= r_found ? r_best_idx : '0;
                            end
                        end
                    end
                end
                default: ;
            endcase
        end
    end

    assign o_valid     = r_out_valid;
    assign o_hit       = r_out_hit;
    assign o_distance  = r_out_dist;
    assign o_box_index = r_out_idx;

`ifndef NO_ASSERTIONS
    a_busy_stalls: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != ST_IDLE) |-> o_stall)
        else $error("input taken while busy");
    a_best_nonneg: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_best[VAL_W-1])
        else $error("best distance negative");
    a_miss_index: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_found |-> (r_best_idx == '0))
        else $error("index kept without a hit");
    a_out_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_FINAL && r_last && r_out_valid && i_stall) |=> (r_state == ST_FINAL))
        else $error("result overwrote waiting item");
`endif

endmodule
